// File: hw/rtl/sdd_pkg.sv
// ---------------------------------------------------------------------------
// sdd_pkg: shared constants and types for the signed decimal display block
// Widths, display-driver codes and the word that travels down the cell row.
// ---------------------------------------------------------------------------
package sdd_pkg;

  // number of decimal digit positions shown (1..7)
  localparam int unsigned NUM_DIGITS = 7;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned DIG_W  = 4;
  localparam int unsigned REG_W  = 4;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned CNT_W  = $clog2(NUM_DIGITS + 1);

  // driver register addresses and code-B values
  localparam logic [REG_W-1:0]  SIGN_REG   = REG_W'(8);
  localparam logic [REG_W-1:0]  DP_REG     = REG_W'(3);
  localparam logic [CODE_W-1:0] CODE_DASH  = CODE_W'(10);
  localparam logic [CODE_W-1:0] CODE_BLANK = CODE_W'(15);
  localparam logic [CODE_W-1:0] DP_BIT     = CODE_W'(8'h80);

  // divide by ten: q = (x * 0xCCCCCCCD) >> 35, exact for any 32-bit x
  localparam logic [VAL_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int unsigned      RECIP_SHIFT = 35;
  localparam int unsigned      QUOT_W      = 2 * VAL_W - RECIP_SHIFT;

  typedef logic [NUM_DIGITS-1:0][DIG_W-1:0] digits_t;

  // word passed from cell to cell
  typedef struct packed {
    logic             neg;
    logic [VAL_W-1:0] mag;
    digits_t          digits;
  } stage_t;

endpackage

// File: hw/rtl/sdd_if.sv
// ---------------------------------------------------------------------------
// sdd_if: valid/ready channels of the signed decimal display block
// Input channel carries the number, output channel one driver frame.
// ---------------------------------------------------------------------------
interface sdd_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [sdd_pkg::VAL_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sdd_out_if;
  logic                        valid;
  logic                        ready;
  logic [sdd_pkg::REG_W-1:0]   digit_register;
  logic [sdd_pkg::CODE_W-1:0]  digit_code;
  logic                        last;

  modport source (output valid, output digit_register, output digit_code, output last,
                  input ready);
  modport sink   (input valid, input digit_register, input digit_code, input last,
                  output ready);
endinterface

// File: hw/rtl/sdd_cell.sv
// ---------------------------------------------------------------------------
// sdd_cell: one digit cell of the conversion row
// Splits off the lowest decimal digit of the magnitude and hands the
// quotient and the collected digits to the next cell.
// ---------------------------------------------------------------------------
module sdd_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  sdd_pkg::stage_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output sdd_pkg::stage_t dn_data
);

  logic                                  valid_r;
  sdd_pkg::stage_t                       data_r;
  sdd_pkg::stage_t                       data_nxt;
  logic [2*sdd_pkg::VAL_W-1:0]           prod;
  logic [sdd_pkg::VAL_W-1:0]             quot;
  logic [sdd_pkg::VAL_W-1:0]             quot_x10;
  logic [sdd_pkg::VAL_W-1:0]             rem;
  logic                                  take;

  assign up_ready = !valid_r || dn_ready;
  assign take     = up_valid && up_ready;

  // reciprocal multiply, then remainder by shift-add
  always_comb begin
    prod     = {{sdd_pkg::VAL_W{1'b0}}, up_data.mag} *
               {{sdd_pkg::VAL_W{1'b0}}, sdd_pkg::RECIP_10};
    quot     = sdd_pkg::VAL_W'(prod[2*sdd_pkg::VAL_W-1:sdd_pkg::RECIP_SHIFT]);
    quot_x10 = (quot << 3) + (quot << 1);
    rem      = up_data.mag - quot_x10;

    data_nxt        = up_data;
    data_nxt.mag    = quot;
    data_nxt.digits = up_data.digits >> sdd_pkg::DIG_W;
    data_nxt.digits[sdd_pkg::NUM_DIGITS-1] = rem[sdd_pkg::DIG_W-1:0];
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// File: hw/rtl/sdd_ser.sv
// ---------------------------------------------------------------------------
// sdd_ser: frame serialiser
// Holds one converted number and sends its sign frame and digit frames,
// one word per cycle while the output channel is ready, to the output channel.
// ---------------------------------------------------------------------------
module sdd_ser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  sdd_pkg::stage_t   up_data,
  sdd_out_if.source         out_chan
);

  logic                         valid_r;
  logic                         valid_nxt;
  logic [sdd_pkg::CNT_W-1:0]    cnt_r;
  logic [sdd_pkg::CNT_W-1:0]    cnt_nxt;
  logic                         neg_r;
  logic                         neg_nxt;
  sdd_pkg::digits_t             digits_r;
  sdd_pkg::digits_t             digits_nxt;
  logic                         is_last;
  logic                         fire;
  logic [sdd_pkg::REG_W-1:0]    frame_reg;
  logic [sdd_pkg::CODE_W-1:0]   frame_code;

  assign is_last  = (cnt_r == sdd_pkg::CNT_W'(sdd_pkg::NUM_DIGITS));
  assign fire     = valid_r && out_chan.ready;
  assign up_ready = !valid_r || (out_chan.ready && is_last);

  // frame contents from counter and digit shift register
  always_comb begin
    if (cnt_r == '0) begin
      frame_reg  = sdd_pkg::SIGN_REG;
      frame_code = neg_r ? sdd_pkg::CODE_DASH : sdd_pkg::CODE_BLANK;
    end else begin
      frame_reg  = sdd_pkg::REG_W'(cnt_r);
      frame_code = sdd_pkg::CODE_W'(digits_r[0]);
      if (frame_reg == sdd_pkg::DP_REG) begin
        frame_code = frame_code | sdd_pkg::DP_BIT;
      end
    end
  end

  // next state: load a new number, step to the next frame, end after the last frame, or hold
  always_comb begin
    valid_nxt  = valid_r;
    cnt_nxt    = cnt_r;
    neg_nxt    = neg_r;
    digits_nxt = digits_r;
    if (up_valid && up_ready) begin
      valid_nxt  = 1'b1;
      cnt_nxt    = '0;
      neg_nxt    = up_data.neg;
      digits_nxt = up_data.digits;
    end else if (fire) begin
      if (is_last) begin
        valid_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r != '0) begin
          digits_nxt = digits_r >> sdd_pkg::DIG_W;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r    <= neg_nxt;
    digits_r <= digits_nxt;
  end

  assign out_chan.valid          = valid_r;
  assign out_chan.digit_register = frame_reg;
  assign out_chan.digit_code     = frame_code;
  assign out_chan.last           = is_last;

  // checks
  a_last_on_top_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && is_last) |-> (frame_reg == sdd_pkg::REG_W'(sdd_pkg::NUM_DIGITS)))
    else $error("last frame not on the top digit register");

  a_sign_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_last) |=> (!valid_r || frame_reg == sdd_pkg::SIGN_REG))
    else $error("number does not start with its sign frame");

  a_dp_position: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && frame_code[sdd_pkg::CODE_W-1]) |-> (frame_reg == sdd_pkg::DP_REG))
    else $error("decimal point on the wrong register");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && cnt_r != '0) |-> (frame_code[sdd_pkg::DIG_W-1:0] <= sdd_pkg::DIG_W'(9)))
    else $error("digit frame carries a non-decimal code");

endmodule

// File: hw/rtl/signed_decimal_display_frames.sv
// ---------------------------------------------------------------------------
// signed_decimal_display_frames: signed number to display-driver frames
// Takes a signed 32-bit number and emits a sign frame followed by the
// low decimal digits of its magnitude, one frame per output word.
//
//   channel    dir  contents                                   handshake
//   in_chan    in   value (32b signed)                         valid/ready
//   out_chan   out  digit_register (4b), digit_code (8b), last valid/ready
//
// Each number is sent as 1 + NUM_DIGITS frames at the output, one frame per
// cycle while the output is ready; a number passes the magnitude stage, the
// digit cells and the serialiser register before its first frame appears.
// Later numbers enter and convert while earlier frames are being sent.
// Reset is synchronous, active low, and empties every stage.
// A stalled output holds the current frame and backs up the cell row.
// ---------------------------------------------------------------------------
module signed_decimal_display_frames (
  input  logic      clk,
  input  logic      rst_n,
  sdd_in_if.sink    in_chan,
  sdd_out_if.source out_chan
);

  localparam int unsigned N = sdd_pkg::NUM_DIGITS;

  logic                    front_valid_r;
  sdd_pkg::stage_t         front_r;
  sdd_pkg::stage_t         front_nxt;
  logic [sdd_pkg::VAL_W-1:0] raw;

  logic                    link_valid [N+1];
  logic                    link_ready [N+1];
  sdd_pkg::stage_t         link_data  [N+1];

  assign in_chan.ready = !front_valid_r || link_ready[0];

  // magnitude stage: two's complement negate of negative numbers
  always_comb begin
    raw              = sdd_pkg::VAL_W'(in_chan.value);
    front_nxt.neg    = raw[sdd_pkg::VAL_W-1];
    front_nxt.mag    = front_nxt.neg ? (~raw + 1'b1) : raw;
    front_nxt.digits = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      front_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      front_r <= front_nxt;
    end
  end

  assign link_valid[0] = front_valid_r;
  assign link_data[0]  = front_r;

  // row of digit cells
  for (genvar g = 0; g < N; g++) begin : g_cell
    sdd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[g]),
      .up_ready (link_ready[g]),
      .up_data  (link_data[g]),
      .dn_valid (link_valid[g+1]),
      .dn_ready (link_ready[g+1]),
      .dn_data  (link_data[g+1])
    );
  end

  // frame output
  sdd_ser u_ser (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (link_valid[N]),
    .up_ready (link_ready[N]),
    .up_data  (link_data[N]),
    .out_chan (out_chan)
  );

endmodule
